// File: hdl/pgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgt_pkg: shared types and constants for the packet gap tracker
// Payload structs, operation codes, bitmap geometry and sequencer states.
// ----------------------------------------------------------------------------
package pgt_pkg;

	localparam int MAX_PACKETS = 4096;
	localparam int MAX_GAPS    = 8;

	localparam int SEQ_W     = 32;
	localparam int CNT_W     = 13;
	localparam int GAP_W     = 12;
	localparam int ROW_W     = 32;
	localparam int ROWS      = MAX_PACKETS / ROW_W;
	localparam int ROW_AW    = $clog2(ROWS);
	localparam int COL_W     = $clog2(ROW_W);
	localparam int POS_W     = $clog2(MAX_PACKETS + 1);
	localparam int GAP_CNT_W = $clog2(MAX_GAPS + 1);

	localparam logic [CNT_W-1:0] TALLY_MAX = {CNT_W{1'b1}};

	localparam logic [1:0] OP_MARK   = 2'd0;
	localparam logic [1:0] OP_REPORT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]       operation;
		logic [SEQ_W-1:0] seq_number;
	} in_t;

	typedef struct packed {
		logic             gap_valid;
		logic [GAP_W-1:0] gap_first;
		logic [GAP_W-1:0] gap_end;
		logic [CNT_W-1:0] received_total;
		logic             last;
	} out_t;

	typedef struct packed {
		logic              clear;
		logic              rd_en;
		logic [ROW_AW-1:0] rd_row;
		logic              wr_en;
		logic [ROW_AW-1:0] wr_row;
		logic [ROW_W-1:0]  wr_data;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MARK,
		ST_FETCH,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

// File: hdl/packet_gap_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_gap_tracker: selective-repeat receive bitmap
// Tracks received sequence numbers and reports ranges of missing packets.
// ----------------------------------------------------------------------------
// Timing: the block takes one transaction at a time and drops in_ready while
// it works. A clear, an unused operation code or a mark beyond the packet
// count is done in the accepting cycle; an in-range mark reads its row, then
// writes it back through the separate bitmap write port. A report walks the
// map with a one-bit-per-cycle scan unit, unless the output side stalls: it
// accepts the request, fetches each 32-bit row, scans each bit position
// below the active count n, then the end position, and closes with a
// final result; it stops early after the eighth gap. Writing packet_count,
// or a clear, empties the map at once through per-row valid flops, so there
// is no clearing pass after reset.
// ----------------------------------------------------------------------------
module packet_gap_tracker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  pgt_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output pgt_pkg::out_t             out_data,
	input  logic                      cfg_we,
	input  logic [pgt_pkg::CNT_W-1:0] cfg_wdata
);
	import pgt_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [POS_W-1:0] active_n;
	mem_req_t         req;
	logic [ROW_W-1:0] rd_data;
	logic             slot_free;
	logic             res_valid;
	out_t             res;
	logic             out_valid_q;
	out_t             out_q;

	// Hold the packet count; a write starts a new transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Clamp the count to the bitmap size.
	assign active_n = (count_q > CNT_W'(MAX_PACKETS)) ? POS_W'(MAX_PACKETS)
	                                                   : POS_W'(count_q);

	pgt_bitmap u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	pgt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.active_n  (active_n),
		.cfg_clear (cfg_we),
		.req       (req),
		.rd_data   (rd_data),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: the sequencer writes a result only when the slot
	// is empty or being drained this cycle.
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// An empty report result always closes its report.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.gap_valid |-> out_data.last)
		else $error("empty result without last");

	// A reported range never runs backward.
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.gap_valid |-> out_data.gap_first <= out_data.gap_end)
		else $error("gap range reversed");

	// A report transaction keeps the input side closed while the scan runs.
	a_report_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.operation == OP_REPORT |=> !in_ready)
		else $error("input accepted during report scan");
`endif

endmodule

// File: hdl/pgt_bitmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgt_bitmap: receive bitmap storage
// Row memory with one registered read port, one write port and per-row valid
// flops; a row that is not valid reads as all zero.
// ----------------------------------------------------------------------------
module pgt_bitmap (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pgt_pkg::mem_req_t        req,
	output logic [pgt_pkg::ROW_W-1:0] rd_data
);
	import pgt_pkg::*;

	logic [ROW_W-1:0] mem [ROWS];
	logic [ROW_W-1:0] rd_word_q;
	logic [ROWS-1:0]  row_valid_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_row] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_word_q <= mem[req.rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (req.clear) begin
				row_valid_q <= '0;
			end else if (req.wr_en) begin
				row_valid_q[req.wr_row] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= row_valid_q[req.rd_row];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_word_q : '0;

endmodule

// File: hdl/pgt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgt_ctrl: sequencer and bit-serial scan unit
// Runs mark read-modify-write, clear and the report scan; keeps the tally.
// ----------------------------------------------------------------------------
module pgt_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  pgt_pkg::in_t              in_data,
	input  logic [pgt_pkg::POS_W-1:0] active_n,
	input  logic                      cfg_clear,
	output pgt_pkg::mem_req_t         req,
	input  logic [pgt_pkg::ROW_W-1:0] rd_data,
	input  logic                      slot_free,
	output logic                      res_valid,
	output pgt_pkg::out_t             res
);
	import pgt_pkg::*;

	state_t state_q, state_d;

	logic [POS_W-1:0]     pos_q;
	logic [GAP_W-1:0]     start_q;
	logic                 in_gap_q;
	logic                 pend_q;
	logic [GAP_W-1:0]     pend_start_q;
	logic [GAP_W-1:0]     pend_end_q;
	logic [GAP_CNT_W-1:0] gaps_q;
	logic [CNT_W-1:0]     tally_q;
	logic [ROW_AW-1:0]    row_q;
	logic [COL_W-1:0]     col_q;

	logic             accept;
	logic             in_range;
	logic             bit_now;
	logic             at_end;
	logic             close;
	logic             stall;
	logic             full;
	logic             mark_bit;
	logic [POS_W-1:0] pos_m1;

	assign accept   = in_valid && in_ready;
	assign in_range = in_data.seq_number < {{(SEQ_W-POS_W){1'b0}}, active_n};
	assign bit_now  = rd_data[pos_q[COL_W-1:0]];
	assign at_end   = pos_q == active_n;
	assign close    = in_gap_q && (at_end || bit_now);
	assign stall    = close && pend_q && !slot_free;
	assign full     = (gaps_q + 1'b1) == GAP_CNT_W'(MAX_GAPS);
	assign mark_bit = rd_data[col_q];
	assign pos_m1   = pos_q - POS_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.operation == OP_MARK && in_range) begin
						state_d = ST_MARK;
					end else if (in_data.operation == OP_REPORT) begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_MARK:  state_d = ST_IDLE;
			ST_FETCH: state_d = ST_SCAN;
			ST_SCAN: begin
				if (!stall) begin
					priority if (at_end || (close && full)) begin
						state_d = ST_FINISH;
					end else if (pos_q[COL_W-1:0] == {COL_W{1'b1}}) begin
						state_d = ST_FETCH;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		req         = '0;
		req.rd_row  = in_data.seq_number[COL_W +: ROW_AW];
		req.wr_row  = row_q;
		req.wr_data = rd_data | (ROW_W'(1) << col_q);
		req.clear   = cfg_clear;
		res_valid   = 1'b0;
		res.gap_valid      = 1'b1;
		res.gap_first      = pend_start_q;
		res.gap_end        = pend_end_q;
		res.received_total = tally_q;
		res.last           = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				req.rd_en = accept && in_data.operation == OP_MARK && in_range;
				if (accept && in_data.operation == OP_CLEAR) begin
					req.clear = 1'b1;
				end
			end
			ST_MARK: begin
				req.wr_en = !mark_bit;
			end
			ST_FETCH: begin
				req.rd_en  = 1'b1;
				req.rd_row = pos_q[COL_W +: ROW_AW];
			end
			ST_SCAN: begin
				res_valid = close && pend_q && slot_free;
			end
			ST_FINISH: begin
				res_valid     = slot_free;
				res.gap_valid = pend_q;
				res.gap_first = pend_q ? pend_start_q : '0;
				res.gap_end   = pend_q ? pend_end_q : '0;
				res.last      = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tally_q  <= '0;
			in_gap_q <= 1'b0;
			pend_q   <= 1'b0;
			gaps_q   <= '0;
			pos_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_clear || (accept && in_data.operation == OP_CLEAR)) begin
				tally_q <= '0;
			end else if (state_q == ST_MARK && !mark_bit && tally_q != TALLY_MAX) begin
				tally_q <= tally_q + 1'b1;
			end
			if (accept && in_data.operation == OP_REPORT) begin
				pos_q    <= '0;
				in_gap_q <= 1'b0;
				pend_q   <= 1'b0;
				gaps_q   <= '0;
			end else if (state_q == ST_SCAN && !stall) begin
				if (close) begin
					pend_q   <= 1'b1;
					in_gap_q <= 1'b0;
					gaps_q   <= gaps_q + 1'b1;
				end else if (!at_end && !bit_now) begin
					in_gap_q <= 1'b1;
				end
				if (!at_end) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= in_data.seq_number[COL_W +: ROW_AW];
			col_q <= in_data.seq_number[COL_W-1:0];
		end
		if (state_q == ST_SCAN && !stall) begin
			if (close) begin
				pend_start_q <= start_q;
				pend_end_q   <= pos_m1[GAP_W-1:0];
			end else if (!at_end && !in_gap_q && !bit_now) begin
				start_q <= pos_q[GAP_W-1:0];
			end
		end
	end

endmodule
